// File: rtl/core/fbat_pkg.sv
`timescale 1ns / 1ps

package fbat_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int MAC_W  = 48;
    localparam int IP_W   = 32;
    localparam int LEN_W  = 16;
    localparam int SUM_W  = 32;
    localparam int MS_W   = 16;
    localparam int KEY_W  = MAC_W + IP_W;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_W   = 1;

    localparam logic [REG_W-1:0] REG_WINDOW_MS = 1'b0;
    localparam logic [MS_W-1:0]  WINDOW_RESET  = 16'd1000;
    localparam logic [MS_W-1:0]  MS_MAX        = '1;
    localparam logic [SUM_W-1:0] SUM_MAX       = '1;

    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] sum,
                                                 input logic [LEN_W-1:0] len);
        logic [SUM_W:0] wide;
        wide = {1'b0, sum} + (SUM_W + 1)'(len);
        return wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
    endfunction

endpackage

// File: rtl/core/fbat_pkt_if.sv
`timescale 1ns / 1ps

interface fbat_pkt_if import fbat_pkg::*; ();

    logic             valid;
    logic             ready;
    logic             cmd;
    logic [MAC_W-1:0] src_mac;
    logic [IP_W-1:0]  src_ip;
    logic [MAC_W-1:0] dst_mac;
    logic [IP_W-1:0]  dst_ip;
    logic [LEN_W-1:0] pkt_len;

    modport source (
        output valid, cmd, src_mac, src_ip, dst_mac, dst_ip, pkt_len,
        input  ready
    );

    modport sink (
        input  valid, cmd, src_mac, src_ip, dst_mac, dst_ip, pkt_len,
        output ready
    );

endinterface

// File: rtl/core/fbat_res_if.sv
`timescale 1ns / 1ps

interface fbat_res_if import fbat_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] src_window_bytes;
    logic [SUM_W-1:0] src_total_bytes;
    logic [SUM_W-1:0] dst_total_bytes;
    logic             src_dropped;
    logic             dst_dropped;

    modport source (
        output valid, src_window_bytes, src_total_bytes, dst_total_bytes,
               src_dropped, dst_dropped,
        input  ready
    );

    modport sink (
        input  valid, src_window_bytes, src_total_bytes, dst_total_bytes,
               src_dropped, dst_dropped,
        output ready
    );

endinterface

// File: rtl/core/flow_byte_accounting_table.sv
`timescale 1ns / 1ps
// Channel | Dir | Transfer when           | Payload
// item    | in  | valid & ready           | cmd, src_mac, src_ip, dst_mac, dst_ip, pkt_len
// result  | out | valid & ready           | src/dst totals, dropped flags
// apb     | in  | psel & penable & pwrite | window_ms at byte address 0
//
// A tick is handled in ST_IDLE as it is taken. A packet walks both tables together in ST_SCAN,
// one entry a cycle, through the registered read of the key memories, then passes ST_RD and
// ST_UPD. When the window has run out, ST_CLEAR first zeroes the window totals of all src_used
// entries.
// Reset is asynchronous and empties both tables; item.ready is low while a packet is in work.
// A result waits in the output register; the next item is taken meanwhile, and a following
// packet holds in its update cycle until that result is taken.

module flow_byte_accounting_table import fbat_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    fbat_pkt_if.sink           item,
    fbat_res_if.source         result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN,
        ST_RD,
        ST_UPD
    } state_t;

    state_t           state_reg, state_next;
    logic [MS_W-1:0]  window_reg, window_next;
    logic [MS_W-1:0]  elapsed_reg, elapsed_next;
    logic [CNT_W-1:0] src_used_reg, src_used_next;
    logic [CNT_W-1:0] dst_used_reg, dst_used_next;
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0] scan_lim_reg, scan_lim_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic             src_hit_reg, src_hit_next;
    logic             dst_hit_reg, dst_hit_next;
    logic [IDX_W-1:0] src_idx_reg, src_idx_next;
    logic [IDX_W-1:0] dst_idx_reg, dst_idx_next;
    logic [KEY_W-1:0] src_key_reg, src_key_next;
    logic [KEY_W-1:0] dst_key_reg, dst_key_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             out_valid_reg, out_valid_next;
    logic [SUM_W-1:0] out_sw_reg, out_sw_next;
    logic [SUM_W-1:0] out_st_reg, out_st_next;
    logic [SUM_W-1:0] out_dt_reg, out_dt_next;
    logic             out_sdrop_reg, out_sdrop_next;
    logic             out_ddrop_reg, out_ddrop_next;

    logic             item_acc;
    logic             cfg_we;
    logic             issue;
    logic             proceed;
    logic [IDX_W-1:0] src_wr_idx;
    logic [IDX_W-1:0] dst_wr_idx;
    logic [SUM_W-1:0] len_ext;
    logic [SUM_W-1:0] src_win_sum;
    logic [SUM_W-1:0] src_tot_sum;
    logic [SUM_W-1:0] dst_tot_sum;

    logic             src_key_we, dst_key_we;
    logic             src_win_we, src_tot_we, dst_tot_we;
    logic [IDX_W-1:0] src_win_waddr;
    logic [SUM_W-1:0] src_win_wdata, src_tot_wdata, dst_tot_wdata;
    logic [KEY_W-1:0] src_key_rdata, dst_key_rdata;
    logic [SUM_W-1:0] src_win_rdata, src_tot_rdata, dst_tot_rdata;

    assign item.ready = (state_reg == ST_IDLE);
    assign item_acc   = item.valid && item.ready;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_WINDOW_MS);
    assign prdata = (paddr[PADDR_W-1:2] == REG_WINDOW_MS) ? PDATA_W'(window_reg) : '0;

    assign issue      = (state_reg == ST_SCAN) && (scan_cnt_reg < scan_lim_reg);
    assign proceed    = !out_valid_reg || result.ready;
    assign src_wr_idx = src_hit_reg ? src_idx_reg : src_used_reg[IDX_W-1:0];
    assign dst_wr_idx = dst_hit_reg ? dst_idx_reg : dst_used_reg[IDX_W-1:0];
    assign len_ext    = SUM_W'(len_reg);

    assign src_win_sum = src_hit_reg ? sat_add(src_win_rdata, len_reg) : len_ext;
    assign src_tot_sum = src_hit_reg ? sat_add(src_tot_rdata, len_reg) : len_ext;
    assign dst_tot_sum = dst_hit_reg ? sat_add(dst_tot_rdata, len_reg) : len_ext;

    always_comb
    begin
        state_next     = state_reg;
        window_next    = window_reg;
        elapsed_next   = elapsed_reg;
        src_used_next  = src_used_reg;
        dst_used_next  = dst_used_reg;
        scan_cnt_next  = scan_cnt_reg;
        scan_lim_next  = scan_lim_reg;
        pend_next      = 1'b0;
        pend_idx_next  = scan_cnt_reg[IDX_W-1:0];
        src_hit_next   = src_hit_reg;
        dst_hit_next   = dst_hit_reg;
        src_idx_next   = src_idx_reg;
        dst_idx_next   = dst_idx_reg;
        src_key_next   = src_key_reg;
        dst_key_next   = dst_key_reg;
        len_next       = len_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_sw_next    = out_sw_reg;
        out_st_next    = out_st_reg;
        out_dt_next    = out_dt_reg;
        out_sdrop_next = out_sdrop_reg;
        out_ddrop_next = out_ddrop_reg;

        src_key_we    = 1'b0;
        dst_key_we    = 1'b0;
        src_win_we    = 1'b0;
        src_tot_we    = 1'b0;
        dst_tot_we    = 1'b0;
        src_win_waddr = src_wr_idx;
        src_win_wdata = src_win_sum;
        src_tot_wdata = src_tot_sum;
        dst_tot_wdata = dst_tot_sum;

        if (cfg_we)
        begin
            window_next = pwdata[MS_W-1:0];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    if (item.cmd == CMD_TICK)
                    begin
                        if (elapsed_reg != MS_MAX)
                        begin
                            elapsed_next = elapsed_reg + MS_W'(1);
                        end
                    end
                    else
                    begin
                        src_key_next  = {item.src_mac, item.src_ip};
                        dst_key_next  = {item.dst_mac, item.dst_ip};
                        len_next      = item.pkt_len;
                        src_hit_next  = 1'b0;
                        dst_hit_next  = 1'b0;
                        scan_cnt_next = '0;
                        scan_lim_next = (src_used_reg > dst_used_reg) ? src_used_reg
                                                                      : dst_used_reg;
                        state_next    = ST_SCAN;
                        if (elapsed_reg >= window_reg)
                        begin
                            elapsed_next = '0;
                            if (src_used_reg != '0)
                            begin
                                state_next = ST_CLEAR;
                            end
                        end
                    end
                end
            end
            ST_CLEAR:
            begin
                src_win_we    = 1'b1;
                src_win_waddr = scan_cnt_reg[IDX_W-1:0];
                src_win_wdata = '0;
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                if (scan_cnt_reg + CNT_W'(1) == src_used_reg)
                begin
                    scan_cnt_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                pend_next = issue;
                if (issue)
                begin
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
                if (pend_reg)
                begin
                    if (!src_hit_reg && (CNT_W'(pend_idx_reg) < src_used_reg)
                        && (src_key_rdata == src_key_reg))
                    begin
                        src_hit_next = 1'b1;
                        src_idx_next = pend_idx_reg;
                    end
                    if (!dst_hit_reg && (CNT_W'(pend_idx_reg) < dst_used_reg)
                        && (dst_key_rdata == dst_key_reg))
                    begin
                        dst_hit_next = 1'b1;
                        dst_idx_next = pend_idx_reg;
                    end
                end
                if (!issue && !pend_reg)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (proceed)
                begin
                    out_valid_next = 1'b1;
                    out_sdrop_next = 1'b0;
                    out_ddrop_next = 1'b0;
                    out_sw_next    = src_win_sum;
                    out_st_next    = src_tot_sum;
                    out_dt_next    = dst_tot_sum;
                    if (src_hit_reg)
                    begin
                        src_win_we = 1'b1;
                        src_tot_we = 1'b1;
                    end
                    else if (src_used_reg < CNT_W'(TABLE_DEPTH))
                    begin
                        src_key_we    = 1'b1;
                        src_win_we    = 1'b1;
                        src_tot_we    = 1'b1;
                        src_used_next = src_used_reg + CNT_W'(1);
                    end
                    else
                    begin
                        out_sdrop_next = 1'b1;
                        out_sw_next    = '0;
                        out_st_next    = '0;
                    end
                    if (dst_hit_reg)
                    begin
                        dst_tot_we = 1'b1;
                    end
                    else if (dst_used_reg < CNT_W'(TABLE_DEPTH))
                    begin
                        dst_key_we    = 1'b1;
                        dst_tot_we    = 1'b1;
                        dst_used_next = dst_used_reg + CNT_W'(1);
                    end
                    else
                    begin
                        out_ddrop_next = 1'b1;
                        out_dt_next    = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= WINDOW_RESET;
            elapsed_reg   <= '0;
            src_used_reg  <= '0;
            dst_used_reg  <= '0;
            scan_cnt_reg  <= '0;
            scan_lim_reg  <= '0;
            pend_reg      <= 1'b0;
            pend_idx_reg  <= '0;
            src_hit_reg   <= 1'b0;
            dst_hit_reg   <= 1'b0;
            src_idx_reg   <= '0;
            dst_idx_reg   <= '0;
            src_key_reg   <= '0;
            dst_key_reg   <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_sw_reg    <= '0;
            out_st_reg    <= '0;
            out_dt_reg    <= '0;
            out_sdrop_reg <= 1'b0;
            out_ddrop_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            elapsed_reg   <= elapsed_next;
            src_used_reg  <= src_used_next;
            dst_used_reg  <= dst_used_next;
            scan_cnt_reg  <= scan_cnt_next;
            scan_lim_reg  <= scan_lim_next;
            pend_reg      <= pend_next;
            pend_idx_reg  <= pend_idx_next;
            src_hit_reg   <= src_hit_next;
            dst_hit_reg   <= dst_hit_next;
            src_idx_reg   <= src_idx_next;
            dst_idx_reg   <= dst_idx_next;
            src_key_reg   <= src_key_next;
            dst_key_reg   <= dst_key_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
            out_sw_reg    <= out_sw_next;
            out_st_reg    <= out_st_next;
            out_dt_reg    <= out_dt_next;
            out_sdrop_reg <= out_sdrop_next;
            out_ddrop_reg <= out_ddrop_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.src_window_bytes = out_sw_reg;
    assign result.src_total_bytes  = out_st_reg;
    assign result.dst_total_bytes  = out_dt_reg;
    assign result.src_dropped      = out_sdrop_reg;
    assign result.dst_dropped      = out_ddrop_reg;

    fbat_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH), .AW(IDX_W)) u_src_key (
        .clk   (clk),
        .we    (src_key_we),
        .waddr (src_wr_idx),
        .wdata (src_key_reg),
        .raddr (scan_cnt_reg[IDX_W-1:0]),
        .rdata (src_key_rdata)
    );

    fbat_ram #(.WIDTH(SUM_W), .DEPTH(TABLE_DEPTH), .AW(IDX_W)) u_src_win (
        .clk   (clk),
        .we    (src_win_we),
        .waddr (src_win_waddr),
        .wdata (src_win_wdata),
        .raddr (src_idx_reg),
        .rdata (src_win_rdata)
    );

    fbat_ram #(.WIDTH(SUM_W), .DEPTH(TABLE_DEPTH), .AW(IDX_W)) u_src_tot (
        .clk   (clk),
        .we    (src_tot_we),
        .waddr (src_wr_idx),
        .wdata (src_tot_wdata),
        .raddr (src_idx_reg),
        .rdata (src_tot_rdata)
    );

    fbat_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH), .AW(IDX_W)) u_dst_key (
        .clk   (clk),
        .we    (dst_key_we),
        .waddr (dst_wr_idx),
        .wdata (dst_key_reg),
        .raddr (scan_cnt_reg[IDX_W-1:0]),
        .rdata (dst_key_rdata)
    );

    fbat_ram #(.WIDTH(SUM_W), .DEPTH(TABLE_DEPTH), .AW(IDX_W)) u_dst_tot (
        .clk   (clk),
        .we    (dst_tot_we),
        .waddr (dst_wr_idx),
        .wdata (dst_tot_wdata),
        .raddr (dst_idx_reg),
        .rdata (dst_tot_rdata)
    );

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (src_used_reg <= CNT_W'(TABLE_DEPTH)) && (dst_used_reg <= CNT_W'(TABLE_DEPTH)))
        else $error("table fill count beyond depth");

    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_UPD)
        else $error("result raised outside update");

    a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_sdrop_reg) |-> src_used_reg == CNT_W'(TABLE_DEPTH))
        else $error("source drop with room left");

    a_window_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (item_acc && item.cmd == CMD_PACKET && elapsed_reg >= window_reg)
        |=> elapsed_reg == '0)
        else $error("window counter not restarted");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> scan_cnt_reg <= scan_lim_reg)
        else $error("scan pointer past limit");

endmodule

// File: rtl/core/fbat_ram.sv
`timescale 1ns / 1ps

module fbat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: bench/flow_totals_checker.sv
`timescale 1ns / 1ps

module flow_totals_checker import fbat_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic [PDATA_W-1:0] prdata,
    input  logic               pready,
    fbat_pkt_if                item,
    fbat_res_if                result,
    output int                 mismatches,
    output int                 outstanding,
    output int                 packets,
    output int                 ticks,
    output int                 clears,
    output int                 drops
);

    typedef struct packed {
        logic [SUM_W-1:0] src_window;
        logic [SUM_W-1:0] src_total;
        logic [SUM_W-1:0] dst_total;
        logic             src_drop;
        logic             dst_drop;
    } flow_totals_t;

    logic [MAC_W-1:0] src_mac_tab [TABLE_DEPTH];
    logic [IP_W-1:0]  src_ip_tab  [TABLE_DEPTH];
    logic [SUM_W-1:0] src_win_tab [TABLE_DEPTH];
    logic [SUM_W-1:0] src_tot_tab [TABLE_DEPTH];
    int               src_fill;

    logic [MAC_W-1:0] dst_mac_tab [TABLE_DEPTH];
    logic [IP_W-1:0]  dst_ip_tab  [TABLE_DEPTH];
    logic [SUM_W-1:0] dst_tot_tab [TABLE_DEPTH];
    int               dst_fill;

    logic [MS_W-1:0]  ms_count;
    logic [MS_W-1:0]  window_len;

    flow_totals_t     pending_totals [$];
    flow_totals_t     want;

    function automatic logic [SUM_W-1:0] clamp_add(input logic [SUM_W-1:0] acc,
                                                   input logic [LEN_W-1:0] len);
        logic [SUM_W:0] wide;
        wide = {1'b0, acc} + (SUM_W + 1)'(len);
        return wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
    endfunction

    function automatic flow_totals_t account_packet(input logic [MAC_W-1:0] smac,
                                                    input logic [IP_W-1:0]  sip,
                                                    input logic [MAC_W-1:0] dmac,
                                                    input logic [IP_W-1:0]  dip,
                                                    input logic [LEN_W-1:0] len);
        flow_totals_t t;
        int           i;
        int           hit;
        t = '0;
        if (ms_count >= window_len)
        begin
            for (i = 0; i < src_fill; i++)
                src_win_tab[i] = '0;
            ms_count = '0;
            clears++;
        end

        hit = -1;
        for (i = 0; i < src_fill; i++)
            if (hit < 0 && src_mac_tab[i] == smac && src_ip_tab[i] == sip)
                hit = i;
        if (hit >= 0)
        begin
            src_win_tab[hit] = clamp_add(src_win_tab[hit], len);
            src_tot_tab[hit] = clamp_add(src_tot_tab[hit], len);
            t.src_window     = src_win_tab[hit];
            t.src_total      = src_tot_tab[hit];
        end
        else if (src_fill < TABLE_DEPTH)
        begin
            src_mac_tab[src_fill] = smac;
            src_ip_tab[src_fill]  = sip;
            src_win_tab[src_fill] = SUM_W'(len);
            src_tot_tab[src_fill] = SUM_W'(len);
            src_fill++;
            t.src_window = SUM_W'(len);
            t.src_total  = SUM_W'(len);
        end
        else
        begin
            t.src_drop = 1'b1;
            drops++;
        end

        hit = -1;
        for (i = 0; i < dst_fill; i++)
            if (hit < 0 && dst_mac_tab[i] == dmac && dst_ip_tab[i] == dip)
                hit = i;
        if (hit >= 0)
        begin
            dst_tot_tab[hit] = clamp_add(dst_tot_tab[hit], len);
            t.dst_total      = dst_tot_tab[hit];
        end
        else if (dst_fill < TABLE_DEPTH)
        begin
            dst_mac_tab[dst_fill] = dmac;
            dst_ip_tab[dst_fill]  = dip;
            dst_tot_tab[dst_fill] = SUM_W'(len);
            dst_fill++;
            t.dst_total = SUM_W'(len);
        end
        else
        begin
            t.dst_drop = 1'b1;
            drops++;
        end
        return t;
    endfunction

    function automatic void check_field(input string name, input logic [SUM_W-1:0] expected,
                                        input logic [SUM_W-1:0] actual);
        if (actual !== expected)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len = WINDOW_RESET;
            ms_count   = '0;
            src_fill   = 0;
            dst_fill   = 0;
            pending_totals.delete();
            mismatches = 0;
            packets    = 0;
            ticks      = 0;
            clears     = 0;
            drops      = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (pending_totals.size() == 0)
                begin
                    $error("result transfer with no packet waiting for it");
                    mismatches++;
                end
                else
                begin
                    want = pending_totals.pop_front();
                    check_field("src_window_bytes", want.src_window, result.src_window_bytes);
                    check_field("src_total_bytes", want.src_total, result.src_total_bytes);
                    check_field("dst_total_bytes", want.dst_total, result.dst_total_bytes);
                    check_field("src_dropped", SUM_W'(want.src_drop),
                                SUM_W'(result.src_dropped));
                    check_field("dst_dropped", SUM_W'(want.dst_drop),
                                SUM_W'(result.dst_dropped));
                end
            end

            if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_WINDOW_MS)
            begin
                if (pwrite)
                    window_len = pwdata[MS_W-1:0];
                else
                    check_field("window_ms", PDATA_W'(window_len), prdata);
            end

            if (item.valid && item.ready)
            begin
                if (item.cmd == CMD_TICK)
                begin
                    ticks++;
                    if (ms_count != MS_MAX)
                        ms_count++;
                end
                else
                begin
                    packets++;
                    pending_totals.push_back(account_packet(item.src_mac, item.src_ip,
                                                            item.dst_mac, item.dst_ip,
                                                            item.pkt_len));
                end
            end
        end
        outstanding = pending_totals.size();
    end

endmodule

// File: bench/flow_byte_accounting_table_tb.sv
`timescale 1ns / 1ps

module flow_byte_accounting_table_tb;
    import fbat_pkg::*;

    localparam int KEY_POOL       = 96;
    localparam int SETTLE_CYCLES  = 160;
    localparam int LONG_HOLD      = 500;
    localparam int STALL_LIMIT    = 4000;
    localparam int SAME_FLOW_RUN  = 8;
    localparam int CROSS_WINDOW   = 10;
    localparam int TICK_RUN       = 40;

    localparam logic [PADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW_MS, 2'b00};
    localparam logic [PADDR_W-1:0] SPARE_ADDR  = {~REG_WINDOW_MS, 2'b00};

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    fbat_pkt_if item_ch ();
    fbat_res_if result_ch ();

    int mismatches;
    int outstanding;
    int packets;
    int ticks;
    int clears;
    int drops;
    int idle_cycles = 0;

    bit steady       = 1'b0;
    bit hold_results = 1'b0;

    logic [MAC_W-1:0] pool_mac [KEY_POOL];
    logic [IP_W-1:0]  pool_ip  [KEY_POOL];

    always #2 clk = ~clk;

    flow_byte_accounting_table uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_ch),
        .result  (result_ch)
    );

    flow_totals_checker totals_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .item        (item_ch),
        .result      (result_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .packets     (packets),
        .ticks       (ticks),
        .clears      (clears),
        .drops       (drops)
    );

    function automatic logic [MAC_W-1:0] rand_mac();
        return {16'($urandom()), $urandom()};
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 90);
    endfunction

    task automatic offer(input logic cmd, input logic [MAC_W-1:0] smac,
                         input logic [IP_W-1:0] sip, input logic [MAC_W-1:0] dmac,
                         input logic [IP_W-1:0] dip, input logic [LEN_W-1:0] len);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.cmd     <= cmd;
        item_ch.src_mac <= smac;
        item_ch.src_ip  <= sip;
        item_ch.dst_mac <= dmac;
        item_ch.dst_ip  <= dip;
        item_ch.pkt_len <= len;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    task automatic send_tick();
        offer(CMD_TICK, rand_mac(), $urandom(), rand_mac(), $urandom(), LEN_W'($urandom()));
    endtask

    task automatic pick_key(output logic [MAC_W-1:0] mac, output logic [IP_W-1:0] ip);
        int r;
        int k;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, KEY_POOL - 1);
        if (r < 80)
        begin
            mac = pool_mac[k];
            ip  = pool_ip[k];
        end
        else if (r < 95)
        begin
            mac = rand_mac();
            ip  = $urandom();
        end
        else
        begin
            mac = {MAC_W{r[0]}};
            ip  = {IP_W{r[1]}};
        end
    endtask

    task automatic random_traffic(input int count, input int tick_pct);
        int               n;
        int               r;
        logic [MAC_W-1:0] smac;
        logic [MAC_W-1:0] dmac;
        logic [IP_W-1:0]  sip;
        logic [IP_W-1:0]  dip;
        logic [LEN_W-1:0] len;
        for (n = 0; n < count; n++)
        begin
            if (n % 50 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < tick_pct)
                send_tick();
            else
            begin
                pick_key(smac, sip);
                pick_key(dmac, dip);
                r = $urandom_range(0, 99);
                if (r < 5)
                    len = '0;
                else if (r < 10)
                    len = '1;
                else if (r < 40)
                    len = LEN_W'($urandom_range(40, 1518));
                else
                    len = LEN_W'($urandom());
                offer(CMD_PACKET, smac, sip, dmac, dip, len);
            end
        end
        steady = 1'b0;
    endtask

    task automatic reg_access(input logic is_write, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic settle();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input logic [MS_W-1:0] ms);
        settle();
        reg_access(1'b1, WINDOW_ADDR, {(PDATA_W - MS_W)'($urandom()), ms});
        reg_access(1'b0, WINDOW_ADDR, '0);
    endtask

    initial
    begin : drain_results
        int span;
        int held;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_results)
            begin
                result_ch.ready <= 1'b0;
                for (held = 0; held < LONG_HOLD; held++)
                    @(posedge clk);
                hold_results = 1'b0;
            end
            result_ch.ready <= 1'b1;
            span = $urandom_range(1, 6);
            repeat (span) @(posedge clk);
            span = pick_gap();
            if (span > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (span) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || psel || (item_ch.valid && item_ch.ready)
            || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int n;
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        item_ch.valid   <= 1'b0;
        item_ch.cmd     <= CMD_PACKET;
        item_ch.src_mac <= '0;
        item_ch.src_ip  <= '0;
        item_ch.dst_mac <= '0;
        item_ch.dst_ip  <= '0;
        item_ch.pkt_len <= '0;

        // share MAC or IP between neighbors so near-miss keys occur
        for (n = 0; n < KEY_POOL; n++)
        begin
            pool_mac[n] = rand_mac();
            pool_ip[n]  = $urandom();
            if (n % 4 == 1)
                pool_mac[n] = pool_mac[n - 1];
            if (n % 4 == 2)
                pool_ip[n] = pool_ip[n - 1];
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        reg_access(1'b0, WINDOW_ADDR, '0);
        set_window(MS_W'(CROSS_WINDOW));

        // repeat one flow back to back
        steady = 1'b1;
        for (n = 0; n < SAME_FLOW_RUN; n++)
            offer(CMD_PACKET, pool_mac[0], pool_ip[0], pool_mac[1], pool_ip[1], '1);
        steady = 1'b0;

        offer(CMD_TICK, '1, '1, '1, '1, '1);
        offer(CMD_TICK, '0, '0, '0, '0, '0);
        offer(CMD_PACKET, '0, '0, '1, '1, '0);
        offer(CMD_PACKET, '1, '1, '0, '0, '1);
        offer(CMD_PACKET, '0, '0, '1, '1, 16'd1);
        offer(CMD_PACKET, '0, '1, '0, '1, 16'd1500);
        offer(CMD_PACKET, '1, '0, '1, '0, 16'd64);
        offer(CMD_PACKET, pool_mac[0], pool_ip[0], pool_mac[1], pool_ip[1], '0);
        offer(CMD_PACKET, pool_mac[0], pool_ip[0], pool_mac[1], pool_ip[1], 16'd1);
        offer(CMD_PACKET, pool_mac[2], pool_ip[2], pool_mac[2], pool_ip[2], 16'd300);
        // stop one tick short of the window, then cross it
        for (n = 0; n < CROSS_WINDOW - 3; n++)
            send_tick();
        offer(CMD_PACKET, '0, '0, '1, '1, 16'd10);
        send_tick();
        offer(CMD_PACKET, '0, '0, '1, '1, 16'd20);
        offer(CMD_PACKET, '1, '1, '0, '0, 16'd30);

        set_window(16'd3);
        hold_results = 1'b1;
        random_traffic(200, 35);

        set_window('0);
        random_traffic(100, 20);

        set_window('1);
        steady = 1'b1;
        for (n = 0; n < TICK_RUN; n++)
            send_tick();
        steady = 1'b0;
        random_traffic(10, 0);

        settle();
        reg_access(1'b1, SPARE_ADDR, $urandom());
        reg_access(1'b0, WINDOW_ADDR, '0);

        set_window(16'd1);
        random_traffic(90, 40);
        settle();
        random_traffic(90, 40);

        set_window(16'd17);
        random_traffic(90, 30);

        settle();
        $display("Run covered %0d packets and %0d ticks at windows 10, 3, 0, 65535, 1 and 17.",
                 packets, ticks);
        $display("Window totals cleared %0d times; %0d new keys dropped on full tables.",
                 clears, drops);
        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
